### hw/rtl/lldh_pkg.sv
// Shared types, constants and codes for the least-loaded dispatcher.
package lldh_pkg;
   localparam int SLOTS = 16;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam int ID_W = 16;
   localparam int COOK_W = 8;
   localparam int PEND_W = 16;
   localparam int AGE_W = 16;
   localparam int MULT_W = 8;
   localparam int TMO_W = 16;
   localparam int RMV_W = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [COOK_W-1:0] COOKS_RESET = 8'd4;
   localparam logic [MULT_W-1:0] MULT_RESET = 8'd2;
   localparam logic [TMO_W-1:0] TMO_RESET = 16'd1000;

   localparam logic [CSR_IDX_W-1:0] REG_COOKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MULT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TMO = 2'd2;

   typedef enum logic [2:0] {
      OP_DISPATCH = 3'd0,
      OP_DONE = 3'd1,
      OP_REPORT = 3'd2,
      OP_HEARTBEAT = 3'd3,
      OP_TICK = 3'd4,
      OP_EXIT = 3'd5
   } op_type;

   localparam logic [1:0] OUT_OK = 2'd0;
   localparam logic [1:0] OUT_FULL = 2'd1;
   localparam logic [1:0] OUT_UNKNOWN = 2'd2;

   typedef struct packed {
      logic [2:0] op;
      logic [ID_W-1:0] worker_id;
      logic [COOK_W-1:0] report_cooks;
      logic [PEND_W-1:0] report_pending;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] assigned_id;
      logic created;
      logic [1:0] outcome;
      logic [RMV_W-1:0] removed_count;
   } rsp_type;

   typedef struct packed {
      logic [COOK_W-1:0] cooks;
      logic [MULT_W-1:0] mult;
      logic [TMO_W-1:0] tmo;
   } cfg_type;
endpackage

### hw/rtl/lldh_req_if.sv
// Valid/ready channel interfaces for request and response items.
interface lldh_req_if;
   logic valid;
   logic ready;
   lldh_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface lldh_rsp_if;
   logic valid;
   logic ready;
   lldh_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/lldh_csr.sv
// Configuration registers written through the plain write port.
module lldh_csr (
   input logic clock,
   input logic reset,
   input logic csr_we,
   input logic [lldh_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [lldh_pkg::CSR_DATA_W-1:0] csr_wdata,
   output lldh_pkg::cfg_type cfg
);
   lldh_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            lldh_pkg::REG_COOKS: cfg_in.cooks = csr_wdata[lldh_pkg::COOK_W-1:0];
            lldh_pkg::REG_MULT: cfg_in.mult = csr_wdata[lldh_pkg::MULT_W-1:0];
            lldh_pkg::REG_TMO: cfg_in.tmo = csr_wdata[lldh_pkg::TMO_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{cooks: lldh_pkg::COOKS_RESET, mult: lldh_pkg::MULT_RESET,
                     tmo: lldh_pkg::TMO_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

### hw/rtl/lldh_engine.sv
// Slot table and sequencer that walks the slots one at a time, one item at a time.
module lldh_engine (
   input logic clock,
   input logic reset,
   input lldh_pkg::cfg_type cfg,
   lldh_req_if.sink req,
   lldh_rsp_if.source rsp
);
   localparam int S = lldh_pkg::SLOTS;
   localparam int SW = lldh_pkg::SLOT_W;
   localparam int CW = lldh_pkg::CNT_W;
   localparam int PW = lldh_pkg::PEND_W;
   localparam int AW = lldh_pkg::AGE_W;
   localparam int IW = lldh_pkg::ID_W;
   localparam int RW = lldh_pkg::RMV_W;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_MUL = 5'b00100,
      ST_COMMIT = 5'b01000,
      ST_OUT = 5'b10000
   } state_type;

   logic [S-1:0] valid_ff, valid_in;
   logic [S-1:0] exited_ff;
   logic [IW-1:0] id_ff [S];
   logic [7:0] cooks_ff [S];
   logic [PW-1:0] pend_ff [S];
   logic [AW-1:0] age_ff [S];

   state_type state_ff, state_in;
   lldh_pkg::req_type item_ff, item_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [RW-1:0] rmv_ff, rmv_in;
   logic best_ok_ff, best_ok_in;
   logic [SW-1:0] best_ff, best_in;
   logic [PW-1:0] best_pend_ff, best_pend_in;
   logic [IW-1:0] best_id_ff, best_id_in;
   logic found_ff, found_in;
   logic [SW-1:0] hit_ff, hit_in;
   logic free_ok_ff, free_ok_in;
   logic [SW-1:0] free_ff, free_in;
   logic [IW-1:0] next_id_ff, next_id_in;
   logic [15:0] cap_ff, cap_in;
   lldh_pkg::rsp_type out_ff, out_in;
   logic out_v_ff, out_v_in;

   logic [SW-1:0] cur;
   logic cur_live, cur_drop, cur_q;
   logic [IW-1:0] nid;

   assign cur = idx_ff[SW-1:0];
   assign cur_drop = valid_ff[cur] &&
      (exited_ff[cur] || (age_ff[cur] > cfg.tmo));
   assign cur_live = valid_ff[cur] && !cur_drop;
   assign cur_q = cur_live && ({16'd0, pend_ff[cur]} < {16'd0, cap_ff});
   assign nid = (next_id_ff == {IW{1'b1}}) ? IW'(1) : next_id_ff + IW'(1);

   assign req.ready = (state_ff == ST_IDLE) && !out_v_ff;
   assign rsp.valid = out_v_ff;
   assign rsp.data = out_ff;

   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      idx_in = idx_ff;
      rmv_in = rmv_ff;
      best_ok_in = best_ok_ff;
      best_in = best_ff;
      best_pend_in = best_pend_ff;
      best_id_in = best_id_ff;
      found_in = found_ff;
      hit_in = hit_ff;
      free_ok_in = free_ok_ff;
      free_in = free_ff;
      cap_in = cap_ff;
      out_in = out_ff;
      out_v_in = out_v_ff;
      valid_in = valid_ff;
      if (out_v_ff && rsp.ready) begin
         out_v_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               item_in = req.data;
               idx_in = '0;
               rmv_in = '0;
               best_ok_in = 1'b0;
               found_in = 1'b0;
               free_ok_in = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cap_in = 16'(cooks_ff[cur]) * 16'(cfg.mult);
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (item_ff.op == 3'(lldh_pkg::OP_DISPATCH)) begin
               if (cur_drop) begin
                  valid_in[cur] = 1'b0;
                  if (rmv_ff != {RW{1'b1}}) rmv_in = rmv_ff + RW'(1);
               end
               if (!cur_live && !free_ok_ff) begin
                  free_ok_in = 1'b1;
                  free_in = cur;
               end
               if (cur_q && (!best_ok_ff || pend_ff[cur] < best_pend_ff ||
                   (pend_ff[cur] == best_pend_ff && id_ff[cur] < best_id_ff))) begin
                  best_ok_in = 1'b1;
                  best_in = cur;
                  best_pend_in = pend_ff[cur];
                  best_id_in = id_ff[cur];
               end
            end else if (!found_ff && valid_ff[cur] && id_ff[cur] == item_ff.worker_id) begin
               found_in = 1'b1;
               hit_in = cur;
            end
            if (idx_ff == CW'(S - 1)) begin
               state_in = ST_COMMIT;
            end else begin
               idx_in = idx_ff + CW'(1);
               state_in = ST_MUL;
            end
         end
         ST_COMMIT: begin
            out_in = '0;
            case (item_ff.op)
               3'(lldh_pkg::OP_DISPATCH): begin
                  out_in.removed_count = rmv_ff;
                  if (best_ok_ff) begin
                     out_in.assigned_id = best_id_ff;
                  end else if (free_ok_ff) begin
                     valid_in[free_ff] = 1'b1;
                     out_in.assigned_id = next_id_ff;
                     out_in.created = 1'b1;
                  end else begin
                     out_in.outcome = lldh_pkg::OUT_FULL;
                  end
               end
               3'(lldh_pkg::OP_DONE), 3'(lldh_pkg::OP_REPORT),
               3'(lldh_pkg::OP_HEARTBEAT), 3'(lldh_pkg::OP_EXIT): begin
                  if (!found_ff) out_in.outcome = lldh_pkg::OUT_UNKNOWN;
               end
               default: out_in = '0;
            endcase
            out_v_in = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign next_id_in = (state_ff == ST_COMMIT && item_ff.op == 3'(lldh_pkg::OP_DISPATCH)
                        && !best_ok_ff && free_ok_ff) ? nid : next_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         out_v_ff <= 1'b0;
         next_id_ff <= IW'(1);
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         out_v_ff <= out_v_in;
         next_id_ff <= next_id_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rmv_ff <= rmv_in;
      best_ok_ff <= best_ok_in;
      best_ff <= best_in;
      best_pend_ff <= best_pend_in;
      best_id_ff <= best_id_in;
      found_ff <= found_in;
      hit_ff <= hit_in;
      free_ok_ff <= free_ok_in;
      free_ff <= free_in;
      cap_ff <= cap_in;
      out_ff <= out_in;
      if (state_ff == ST_SCAN && item_ff.op == 3'(lldh_pkg::OP_TICK) &&
          valid_ff[cur] && age_ff[cur] != {AW{1'b1}}) begin
         age_ff[cur] <= age_ff[cur] + AW'(1);
      end
      if (state_ff == ST_COMMIT) begin
         case (item_ff.op)
            3'(lldh_pkg::OP_DISPATCH): begin
               if (best_ok_ff) begin
                  if (pend_ff[best_ff] != {PW{1'b1}}) pend_ff[best_ff] <= pend_ff[best_ff] + PW'(1);
                  age_ff[best_ff] <= '0;
               end else if (free_ok_ff) begin
                  id_ff[free_ff] <= next_id_ff;
                  cooks_ff[free_ff] <= cfg.cooks;
                  pend_ff[free_ff] <= PW'(1);
                  age_ff[free_ff] <= '0;
                  exited_ff[free_ff] <= 1'b0;
               end
            end
            3'(lldh_pkg::OP_DONE): if (found_ff) begin
               if (pend_ff[hit_ff] != '0) pend_ff[hit_ff] <= pend_ff[hit_ff] - PW'(1);
               age_ff[hit_ff] <= '0;
            end
            3'(lldh_pkg::OP_REPORT): if (found_ff) begin
               cooks_ff[hit_ff] <= item_ff.report_cooks;
               pend_ff[hit_ff] <= item_ff.report_pending;
               age_ff[hit_ff] <= '0;
            end
            3'(lldh_pkg::OP_HEARTBEAT): if (found_ff) age_ff[hit_ff] <= '0;
            3'(lldh_pkg::OP_EXIT): if (found_ff) exited_ff[hit_ff] <= 1'b1;
            default: ;
         endcase
      end
   end
endmodule

### hw/rtl/least_loaded_dispatcher_heartbeat.sv
// Top level of the least-loaded dispatcher with heartbeat supervision.
// Usage:
//   req channel carries one command item (dispatch, completion, report,
//   heartbeat, tick, exit); rsp channel returns exactly one result per item.
//   csr port writes cooks_per_worker (0), load_multiplier (1), stale timeout
//   (2); the user writes only while the block is idle; it is not enforced.
// Sequence:
//   every item walks the slot table one slot at a time (capacity multiply,
//   then compare); a commit state then registers the result on rsp, and an
//   out state returns to idle, where the next item is taken once rsp_ready
//   has drained the result; the shared multiplier and the one-slot compare
//   set this pace.
//   req_ready is low while an item is in flight or a result waits.
// Reset:
//   synchronous; empties the table, sets next id to 1 and the registers to
//   their defaults. No clearing pass is needed.
// Stall:
//   a result holds on rsp until taken; no new item is accepted meanwhile.
module least_loaded_dispatcher_heartbeat (
   input logic clock,
   input logic reset,
   lldh_req_if.sink req_ch,
   lldh_rsp_if.source rsp_ch,
   input logic csr_we,
   input logic [lldh_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [lldh_pkg::CSR_DATA_W-1:0] csr_wdata
);
   lldh_pkg::cfg_type cfg;

   lldh_csr u_csr (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .cfg(cfg)
   );

   lldh_engine u_engine (
      .clock(clock), .reset(reset), .cfg(cfg), .req(req_ch), .rsp(rsp_ch)
   );
endmodule

### hw/rtl/lldh_checker.sv
// Port-level checker for the dispatcher, bound to the top level.
module lldh_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input lldh_pkg::rsp_type rsp_data
);
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("item accepted while result pending");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("ready after accept");
   a_created_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.created) |-> (rsp_data.outcome == lldh_pkg::OUT_OK &&
      rsp_data.assigned_id != '0)) else $error("bad create result");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result dropped");
endmodule

bind least_loaded_dispatcher_heartbeat lldh_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_ch.valid), .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_data(rsp_ch.data)
);
